@@ hdl/lfra_pkg.sv @@
package lfra_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // config register indexes
  localparam logic [1:0] REG_FOCUS_GAIN   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic        in_range;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [23:0] tl;
    logic [23:0] tr;
    logic [23:0] bl;
    logic [23:0] br;
    logic        last;
    logic [11:0] px;
    logic [11:0] py;
  } lfra_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } lfra_qctl_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } lfra_qstat_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_INIT = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } lfra_state_t;

endpackage

@@ hdl/lfra_if.sv @@
interface lfra_in_if;
  logic               valid;
  logic               ready;
  logic [11:0]        pix_x;
  logic [11:0]        pix_y;
  logic signed [12:0] view_u;
  logic signed [12:0] view_v;
  logic [23:0]        nb_top_left;
  logic [23:0]        nb_top_right;
  logic [23:0]        nb_bottom_left;
  logic [23:0]        nb_bottom_right;
  logic               last_view;
  modport source(output valid, pix_x, pix_y, view_u, view_v, nb_top_left, nb_top_right,
                 nb_bottom_left, nb_bottom_right, last_view, input ready);
  modport sink(input valid, pix_x, pix_y, view_u, view_v, nb_top_left, nb_top_right,
               nb_bottom_left, nb_bottom_right, last_view, output ready);
endinterface

interface lfra_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_x;
  logic [11:0] out_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        covered;
  modport source(output valid, out_x, out_y, red, green, blue, covered, input ready);
  modport sink(input valid, out_x, out_y, red, green, blue, covered, output ready);
endinterface

@@ hdl/lfra_front.sv @@
module lfra_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst,
  lfra_in_if.sink             sample,
  input  logic signed [15:0]  focus_gain,
  input  logic [12:0]         image_width,
  input  logic [12:0]         image_height,
  input  lfra_pkg::lfra_qstat_t qstat,
  output logic                push,
  output lfra_pkg::lfra_item_t push_item
);
  import lfra_pkg::*;

  logic               f_v;
  logic signed [28:0] prod_x;
  logic signed [28:0] prod_y;
  logic [11:0]        px;
  logic [11:0]        py;
  logic [23:0]        tl, tr, bl, br;
  logic               last;

  logic signed [16:0] sh_x, sh_y;
  logic signed [22:0] pos_x, pos_y;
  logic [12:0]        w_c, h_c;
  logic signed [22:0] lim_x, lim_y;

  assign sample.ready = !f_v || !qstat.full;
  assign push         = f_v && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (sample.ready) begin
      f_v <= sample.valid;
    end
    if (sample.ready && sample.valid) begin
      prod_x <= focus_gain * sample.view_u;
      prod_y <= focus_gain * sample.view_v;
      px     <= sample.pix_x;
      py     <= sample.pix_y;
      tl     <= sample.nb_top_left;
      tr     <= sample.nb_top_right;
      bl     <= sample.nb_bottom_left;
      br     <= sample.nb_bottom_right;
      last   <= sample.last_view;
    end
  end

  // floor division by 4096 is an arithmetic shift
  assign sh_x  = 17'(prod_x >>> 12);
  assign sh_y  = 17'(prod_y >>> 12);
  assign pos_x = $signed({3'b000, px, 8'h00}) + 23'(sh_x);
  assign pos_y = $signed({3'b000, py, 8'h00}) + 23'(sh_y);

  assign w_c   = (image_width  > 13'(MAX_DIM)) ? 13'(MAX_DIM) : image_width;
  assign h_c   = (image_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : image_height;
  assign lim_x = $signed({2'b00, w_c, 8'h00}) - 23'sd256;
  assign lim_y = $signed({2'b00, h_c, 8'h00}) - 23'sd256;

  always_comb begin
    push_item.in_range = !pos_x[22] && (pos_x < lim_x) && !pos_y[22] && (pos_y < lim_y);
    push_item.dx       = pos_x[7:0];
    push_item.dy       = pos_y[7:0];
    push_item.tl       = tl;
    push_item.tr       = tr;
    push_item.bl       = bl;
    push_item.br       = br;
    push_item.last     = last;
    push_item.px       = px;
    push_item.py       = py;
  end
endmodule

@@ hdl/lfra_queue.sv @@
module lfra_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  lfra_pkg::lfra_qctl_t  ctl,
  input  lfra_pkg::lfra_item_t  wr_item,
  output lfra_pkg::lfra_item_t  rd_item,
  output lfra_pkg::lfra_qstat_t stat
);
  import lfra_pkg::*;

  lfra_item_t       mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     count;

  assign stat.nonempty = (count != '0);
  assign stat.full     = (count == (QAW+1)'(QDEPTH));
  assign rd_item       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wr_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) wr_ptr <= wr_ptr + 1'b1;
      if (ctl.pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({ctl.push, ctl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

@@ hdl/lfra_back.sv @@
module lfra_back #(
  parameter int MAX_VIEWS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lfra_pkg::lfra_item_t  head,
  input  lfra_pkg::lfra_qstat_t qstat,
  output logic                  pop,
  lfra_out_if.source            result
);
  import lfra_pkg::*;

  localparam int CW = $clog2(MAX_VIEWS + 1);

  lfra_state_t state;
  logic [16:0] top [3];
  logic [16:0] bot [3];
  logic        it_inside;
  logic [7:0]  it_dy;
  logic        it_last;
  logic [11:0] it_px, it_py;
  logic [31:0] sum [3];
  logic [CW-1:0] cnt;
  logic [33:0] rem [3];
  logic [33:0] dsh;
  logic [7:0]  q [3];
  logic        ovf [3];
  logic [2:0]  step;
  logic [33:0] num [3];
  logic [8:0]  wx, wy;
  logic        res_load;

  assign pop      = (state == S_IDLE) && qstat.nonempty;
  assign wx       = 9'd256 - {1'b0, head.dx};
  assign wy       = 9'd256 - {1'b0, it_dy};
  assign res_load = (state == S_DONE) && (!result.valid || result.ready);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = {2'b00, sum[c]} + (34'(cnt) << 15);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result.valid <= 1'b0;
      for (int c = 0; c < 3; c++) sum[c] <= '0;
    end else begin
      if (res_load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (qstat.nonempty) begin
            for (int c = 0; c < 3; c++) begin
              top[c] <= 17'(wx * head.tl[23-8*c -: 8]) + 17'({1'b0, head.dx} * head.tr[23-8*c -: 8]);
              bot[c] <= 17'(wx * head.bl[23-8*c -: 8]) + 17'({1'b0, head.dx} * head.br[23-8*c -: 8]);
            end
            it_inside <= head.in_range;
            it_dy     <= head.dy;
            it_last   <= head.last;
            it_px     <= head.px;
            it_py     <= head.py;
            state     <= S_ACC;
          end
        end
        S_ACC: begin
          if (it_inside && (cnt < CW'(MAX_VIEWS))) begin
            for (int c = 0; c < 3; c++) begin
              sum[c] <= sum[c] + 32'(wy * top[c]) + 32'({1'b0, it_dy} * bot[c]);
            end
            cnt <= cnt + 1'b1;
          end
          state <= it_last ? S_INIT : S_IDLE;
        end
        S_INIT: begin
          // quotient above 255 clamps, so eight restoring steps suffice
          for (int c = 0; c < 3; c++) begin
            rem[c] <= num[c];
            ovf[c] <= num[c] >= (34'(cnt) << 24);
            q[c]   <= '0;
          end
          dsh   <= 34'(cnt) << 23;
          step  <= 3'd7;
          state <= S_DIV;
        end
        S_DIV: begin
          for (int c = 0; c < 3; c++) begin
            if (rem[c] >= dsh) begin
              rem[c] <= rem[c] - dsh;
              q[c]   <= {q[c][6:0], 1'b1};
            end else begin
              q[c]   <= {q[c][6:0], 1'b0};
            end
          end
          dsh  <= dsh >> 1;
          step <= step - 1'b1;
          if (step == 3'd0) state <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            result.out_x   <= it_px;
            result.out_y   <= it_py;
            result.covered <= (cnt != '0);
            result.red     <= (cnt == '0) ? 8'd0 : (ovf[0] ? 8'hff : q[0]);
            result.green   <= (cnt == '0) ? 8'd0 : (ovf[1] ? 8'hff : q[1]);
            result.blue    <= (cnt == '0) ? 8'd0 : (ovf[2] ? 8'hff : q[2]);
            for (int c = 0; c < 3; c++) sum[c] <= '0;
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/light_field_refocus_accumulator.sv @@
// channel   dir  handshake      beat
// sample    in   valid/ready    one view of one output pixel
// result    out  valid/ready    one finished pixel, on the last view
// cfg       in   cfg_we         focus_gain, image_width, image_height
//
// front: multiply stage, then position and range check, beats go to a 4-deep queue
// back: each view is interpolated, then accumulated; a last view also goes through
// S_INIT, the 8-step restoring divide and the result load
// result register lets the back go on while a pixel waits to be taken
// rst is synchronous; registers come back as focus 0, width and height 4096
module light_field_refocus_accumulator #(
  parameter int MAX_VIEWS = 256,
  parameter int MAX_DIM   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  lfra_in_if.sink     sample_ch,
  lfra_out_if.source  result_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lfra_pkg::*;

  logic signed [15:0] focus_gain;
  logic [12:0]        image_width;
  logic [12:0]        image_height;
  lfra_qctl_t         qctl;
  lfra_qstat_t        qstat;
  lfra_item_t         push_item, head;
  logic               q_push, q_pop;

  assign qctl = {q_push, q_pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_gain   <= '0;
      image_width  <= 13'd4096;
      image_height <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCUS_GAIN:   focus_gain   <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  lfra_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk, .rst, .sample(sample_ch), .focus_gain, .image_width, .image_height,
    .qstat, .push(q_push), .push_item
  );

  lfra_queue u_queue (
    .clk, .rst, .ctl(qctl), .wr_item(push_item), .rd_item(head), .stat(qstat)
  );

  lfra_back #(.MAX_VIEWS(MAX_VIEWS)) u_back (
    .clk, .rst, .head, .qstat, .pop(q_pop), .result(result_ch)
  );
endmodule

@@ hdl/lfra_checker.sv @@
module lfra_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_x,
  input logic [11:0] out_y,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic        covered
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({out_x, out_y, red, green, blue, covered}))
    else $error("result changed while stalled");

  a_uncovered: assert property (@(posedge clk) disable iff (rst)
    out_valid && !covered |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("uncovered pixel with color");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind light_field_refocus_accumulator lfra_checker u_lfra_checker (
  .clk(clk), .rst(rst), .out_valid(result_ch.valid), .out_ready(result_ch.ready),
  .out_x(result_ch.out_x), .out_y(result_ch.out_y), .red(result_ch.red),
  .green(result_ch.green), .blue(result_ch.blue), .covered(result_ch.covered)
);

@@ dv/light_field_refocus_accumulator_tb.sv @@
module light_field_refocus_accumulator_tb;
  import lfra_pkg::*;

  typedef struct {
    logic [11:0]        pix_x;
    logic [11:0]        pix_y;
    logic signed [12:0] view_u;
    logic signed [12:0] view_v;
    logic [23:0]        tl;
    logic [23:0]        tr;
    logic [23:0]        bl;
    logic [23:0]        br;
    logic               last;
  } view_beat_t;

  typedef struct {
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        covered;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_FOCUS_GAIN;
  logic [15:0] cfg_data = '0;

  lfra_in_if  sample_ch();
  lfra_out_if result_ch();

  light_field_refocus_accumulator u_top (
    .clk(clk), .rst(rst), .sample_ch(sample_ch.sink), .result_ch(result_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] gain_q;
  logic [12:0]        width_q;
  logic [12:0]        height_q;
  logic [31:0]        acc_r, acc_g, acc_b;
  logic [8:0]         hits;

  view_beat_t pending[$];
  pixel_t     pixels_due[$];
  int         errors = 0;
  bit         send_hold = 1'b0;
  bit         feeding = 1'b0;

  function automatic longint view_shift(logic signed [12:0] off);
    longint prod;
    prod = longint'(gain_q) * longint'(off);
    return prod >>> 12;
  endfunction

  function automatic longint edge_limit(logic [12:0] dim);
    longint d;
    d = (dim > 13'd4096) ? 4096 : longint'(dim);
    return (d - 1) * 256;
  endfunction

  function automatic logic [31:0] blend(view_beat_t b, int sh, int dx, int dy);
    int unsigned t, m;
    t = (256 - dx) * ((b.tl >> sh) & 8'hff) + dx * ((b.tr >> sh) & 8'hff);
    m = (256 - dx) * ((b.bl >> sh) & 8'hff) + dx * ((b.br >> sh) & 8'hff);
    return (256 - dy) * t + dy * m;
  endfunction

  function automatic logic [7:0] mean_chan(logic [31:0] s, logic [8:0] n);
    longint unsigned q;
    q = (longint'(s) + (longint'(n) << 15)) / (longint'(n) << 16);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  task automatic predict_view(view_beat_t b);
    longint px, py;
    pixel_t p;
    px = longint'(b.pix_x) * 256 + view_shift(b.view_u);
    py = longint'(b.pix_y) * 256 + view_shift(b.view_v);
    if (px >= 0 && px < edge_limit(width_q) && py >= 0 && py < edge_limit(height_q)
        && hits < 256) begin
      acc_r += blend(b, 16, int'(px & 255), int'(py & 255));
      acc_g += blend(b, 8, int'(px & 255), int'(py & 255));
      acc_b += blend(b, 0, int'(px & 255), int'(py & 255));
      hits++;
    end
    if (b.last) begin
      p.out_x = b.pix_x;
      p.out_y = b.pix_y;
      if (hits == 0) begin
        p.red = 0; p.green = 0; p.blue = 0; p.covered = 0;
      end else begin
        p.red = mean_chan(acc_r, hits);
        p.green = mean_chan(acc_g, hits);
        p.blue = mean_chan(acc_b, hits);
        p.covered = 1;
      end
      pixels_due.push_back(p);
      acc_r = 0; acc_g = 0; acc_b = 0; hits = 0;
    end
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      end
      if (!(sample_ch.valid && !sample_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_ch.valid <= 1'b0;
        end else if (pending.size() > 0 && !send_hold) begin
          view_beat_t b;
          b = pending.pop_front();
          predict_view(b);
          sample_ch.valid <= 1'b1;
          sample_ch.pix_x <= b.pix_x;
          sample_ch.pix_y <= b.pix_y;
          sample_ch.view_u <= b.view_u;
          sample_ch.view_v <= b.view_v;
          sample_ch.nb_top_left <= b.tl;
          sample_ch.nb_top_right <= b.tr;
          sample_ch.nb_bottom_left <= b.bl;
          sample_ch.nb_bottom_right <= b.br;
          sample_ch.last_view <= b.last;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pixels_due.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          pixel_t e;
          e = pixels_due.pop_front();
          if (result_ch.out_x !== e.out_x) begin
            $error("out_x exp %0d got %0d", e.out_x, result_ch.out_x); errors++;
          end
          if (result_ch.out_y !== e.out_y) begin
            $error("out_y exp %0d got %0d", e.out_y, result_ch.out_y); errors++;
          end
          if (result_ch.red !== e.red) begin
            $error("red exp %0d got %0d", e.red, result_ch.red); errors++;
          end
          if (result_ch.green !== e.green) begin
            $error("green exp %0d got %0d", e.green, result_ch.green); errors++;
          end
          if (result_ch.blue !== e.blue) begin
            $error("blue exp %0d got %0d", e.blue, result_ch.blue); errors++;
          end
          if (result_ch.covered !== e.covered) begin
            $error("covered exp %0d got %0d", e.covered, result_ch.covered); errors++;
          end
        end
        recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FOCUS_GAIN:   gain_q = val;
      REG_IMAGE_WIDTH:  width_q = val[12:0];
      REG_IMAGE_HEIGHT: height_q = val[12:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !(sample_ch.valid === 1'b1));
    wait (pixels_due.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic view_beat_t rand_beat(bit last, int dim);
    view_beat_t b;
    b.pix_x = (dim > 0) ? 12'($urandom_range(0, dim - 1)) : 12'($urandom);
    b.pix_y = (dim > 0) ? 12'($urandom_range(0, dim - 1)) : 12'($urandom);
    b.view_u = 13'($urandom);
    b.view_v = 13'($urandom);
    if ($urandom_range(0, 1)) begin
      b.view_u = $signed(13'($urandom_range(0, 1023))) - 13'sd512;
      b.view_v = $signed(13'($urandom_range(0, 1023))) - 13'sd512;
    end
    b.tl = 24'($urandom); b.tr = 24'($urandom);
    b.bl = 24'($urandom); b.br = 24'($urandom);
    b.last = last;
    return b;
  endfunction

  task automatic add_pixel(int views, int dim);
    view_beat_t b;
    logic [11:0] x, y;
    b = rand_beat(0, dim);
    x = b.pix_x; y = b.pix_y;
    for (int i = 0; i < views; i++) begin
      b = rand_beat(i == views - 1, dim);
      if ($urandom_range(0, 7) != 0) begin
        b.pix_x = x; b.pix_y = y;
      end
      pending.push_back(b);
    end
  endtask

  task automatic phase(logic [15:0] g, logic [15:0] w, logic [15:0] h, int n, int dim);
    int sent;
    drain();
    write_reg(REG_FOCUS_GAIN, g);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    sent = 0;
    while (sent < n) begin
      int v;
      v = $urandom_range(1, 12);
      add_pixel(v, dim);
      sent += v;
    end
  endtask

  initial begin
    view_beat_t b;
    gain_q = 0; width_q = 4096; height_q = 4096;
    acc_r = 0; acc_g = 0; acc_b = 0; hits = 0;
    sample_ch.valid = 1'b0;
    sample_ch.pix_x = '0; sample_ch.pix_y = '0;
    sample_ch.view_u = '0; sample_ch.view_v = '0;
    sample_ch.nb_top_left = '0; sample_ch.nb_top_right = '0;
    sample_ch.nb_bottom_left = '0; sample_ch.nb_bottom_right = '0;
    sample_ch.last_view = 1'b0;
    result_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, corners, all-white, all-black, no coverage
    b = '{12'd0, 12'd0, 13'sd0, 13'sd0, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 1'b1};
    pending.push_back(b);
    b = '{12'd4095, 12'd4095, 13'sd0, 13'sd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1};
    pending.push_back(b);
    b = '{12'd4094, 12'd4094, 13'sd0, 13'sd0, 24'hff00ff, 24'h00ff00, 24'h123456,
          24'hfedcba, 1'b0};
    pending.push_back(b);
    b = '{12'd4094, 12'd4094, 13'sd4095, 13'sh1000, 24'hffffff, 24'hffffff, 24'hffffff,
          24'hffffff, 1'b1};
    pending.push_back(b);
    drain();
    write_reg(REG_FOCUS_GAIN, 16'h7fff);
    write_reg(REG_IMAGE_WIDTH, 16'd2);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    b = '{12'd0, 12'd0, 13'sd255, 13'sd255, 24'hffffff, 24'h0, 24'h808080, 24'hffffff, 1'b1};
    pending.push_back(b);
    b = '{12'd0, 12'd0, -13'sd1, 13'sd0, 24'hffffff, 24'h0, 24'h0, 24'h0, 1'b1};
    pending.push_back(b);
    b = '{12'd0, 12'd0, 13'sd0, 13'sd0, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 1'b0};
    pending.push_back(b);
    b = '{12'd0, 12'd0, 13'sd0, 13'sd0, 24'hfefefe, 24'hffffff, 24'hffffff, 24'hffffff, 1'b1};
    pending.push_back(b);
    drain();
    write_reg(REG_FOCUS_GAIN, 16'h8000);
    write_reg(REG_IMAGE_WIDTH, 16'd1);
    write_reg(REG_IMAGE_HEIGHT, 16'd8191);
    b = '{12'd0, 12'd5, 13'sh1000, 13'sd0, 24'hffffff, 24'h0, 24'h0, 24'h0, 1'b1};
    pending.push_back(b);
    b = '{12'd0, 12'd5, 13'sd0, 13'sd0, 24'hffffff, 24'h0, 24'h0, 24'h0, 1'b1};
    pending.push_back(b);
    drain();
    // too many views: more than 256 hits in one pixel
    write_reg(REG_FOCUS_GAIN, 16'd0);
    write_reg(REG_IMAGE_WIDTH, 16'd4096);
    write_reg(REG_IMAGE_HEIGHT, 16'd4096);
    for (int i = 0; i < 300; i++) begin
      b = rand_beat(i == 299, 4095);
      b.tl = (i < 256) ? 24'h000000 : 24'hffffff;
      b.tr = b.tl; b.bl = b.tl; b.br = b.tl;
      pending.push_back(b);
    end

    // pause until everything has come
    drain();
    send_hold = 1'b1;
    repeat (20) @(posedge clk);
    send_hold = 1'b0;

    phase(16'h1000, 16'd64, 16'd48, 250, 64);
    phase(16'($urandom), 16'd4096, 16'd4096, 250, 0);
    phase(16'h7fff, 16'd3, 16'd2, 150, 4);
    phase(16'h8000, 16'd300, 16'd5000, 150, 300);
    phase(16'($urandom), 16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)), 200, 40);
    phase(16'($urandom), 16'($urandom), 16'($urandom), 200, 0);
    drain();
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
